### hw/rtl/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg
// Shared types and constants of the four-lane block digest: lane seeds, mixing
// constants, sequencer states and the request/response bundle of the
// shared 64-bit multiplier.
// ----------------------------------------------------------------------------
package fld_pkg;

  localparam int unsigned LANE_COUNT = 4;
  localparam int unsigned LANE_IDX_W = 2;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [WORD_W-1:0] LANE_START [LANE_COUNT] = '{
    64'h243F6A8885A308D3, 64'h13198A2E03707344,
    64'hA4093822299F31D0, 64'h082EFA98EC4E6C89
  };

  localparam logic [WORD_W-1:0] LANE0_MULT = 64'h00000100000001B3;
  localparam logic [WORD_W-1:0] GOLDEN     = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] IDX_MULT   = 64'h000000000000009D;
  localparam logic [WORD_W-1:0] LANE2_MULT = 64'hD6E8FEB86659FD93;
  localparam logic [WORD_W-1:0] LANE3_ADD  = 64'hC2B2AE3D27D4EB4F;
  localparam logic [WORD_W-1:0] MIX_MULT1  = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MIX_MULT2  = 64'h94D049BB133111EB;

  // lane number times the golden constant, mod 2^64
  localparam logic [WORD_W-1:0] FIN_OFFSET [LANE_COUNT] = '{
    64'h0000000000000000, 64'h9E3779B97F4A7C15,
    64'h3C6EF372FE94F82A, 64'hDAA66D2C7DDF743F
  };

  localparam logic [1:0] MUL_LAST_STEP = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MUL_L0  = 8'b0000_0010,
    ST_MUL_IX  = 8'b0000_0100,
    ST_MUL_L2  = 8'b0000_1000,
    ST_FIN_MIX = 8'b0001_0000,
    ST_FIN_M1  = 8'b0010_0000,
    ST_FIN_M2  = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } fld_state_e;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] p;
  } mul_rsp_t;

endpackage

### hw/rtl/fld_mul.sv
// ----------------------------------------------------------------------------
// fld_mul
// Shared 64x64 multiplier, low 64 bits of the product, built from one 32x32
// multiplier and an accumulator that sums three partial products.
// ----------------------------------------------------------------------------
module fld_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fld_pkg::mul_req_t req_i,
  output fld_pkg::mul_rsp_t rsp_o
);
  import fld_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [1:0]        step_q;
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [WORD_W-1:0] acc_q;
  logic [WORD_W-1:0] acc_d;
  logic [HALF_W-1:0] mx;
  logic [HALF_W-1:0] my;
  logic [WORD_W-1:0] prod;
  logic              take;

  assign take = req_i.start && !busy_q;

  // partial products: lo*lo, then the two cross terms shifted up by 32
  always_comb begin
    case (step_q)
      2'd0: begin
        mx = a_q[HALF_W-1:0];
        my = b_q[HALF_W-1:0];
      end
      2'd1: begin
        mx = a_q[HALF_W-1:0];
        my = b_q[WORD_W-1:HALF_W];
      end
      default: begin
        mx = a_q[WORD_W-1:HALF_W];
        my = b_q[HALF_W-1:0];
      end
    endcase
    prod = WORD_W'(mx) * WORD_W'(my);
    if (step_q == 2'd0) begin
      acc_d = prod;
    end else begin
      acc_d = acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (take) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == MUL_LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

### hw/rtl/four_lane_block_digest.sv
// ----------------------------------------------------------------------------
// four_lane_block_digest
// 256-bit non-cryptographic fingerprint of a byte block over four 64-bit lanes.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        in_valid_i / in_ready_o   data_byte_i, has_byte_i, last_i
//  out       out_valid_o / out_ready_i digest_word0_o .. digest_word3_o
//  seed      seed_we_i (no wait)       seed_i
//
// every 64-bit multiply runs on one shared 32x32 unit
// a byte item takes three multiplies, a byteless non-last item takes none
// a last item adds finalisation (two multiplies per lane) + emit
// in_ready_o is low while an item is being worked on
// emit waits only while the previous digest is still held in the output register
// reset loads the lanes from a zero seed and clears the byte count
// ----------------------------------------------------------------------------
module four_lane_block_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [63:0] seed_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word0_o,
  output logic [63:0] digest_word1_o,
  output logic [63:0] digest_word2_o,
  output logic [63:0] digest_word3_o
);
  import fld_pkg::*;

  fld_state_e            state_q, state_d;
  logic [WORD_W-1:0]     lane_q [LANE_COUNT];
  logic [WORD_W-1:0]     lane_d [LANE_COUNT];
  logic [WORD_W-1:0]     count_q, count_d;
  logic [WORD_W-1:0]     seed_q;
  logic [BYTE_W-1:0]     byte_q, byte_d;
  logic                  last_q, last_d;
  logic [LANE_IDX_W-1:0] fin_idx_q, fin_idx_d;
  logic [WORD_W-1:0]     fin_v_q, fin_v_d;
  logic                  out_valid_q, out_valid_d;
  logic [WORD_W-1:0]     word_q [LANE_COUNT];
  logic [WORD_W-1:0]     word_d [LANE_COUNT];
  logic [WORD_W-1:0]     byte_ext;
  logic [WORD_W-1:0]     sum1;
  logic [WORD_W-1:0]     mix;
  logic [WORD_W-1:0]     mix3;
  mul_req_t              mul_req;
  mul_rsp_t              mul_rsp;

  fld_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign byte_ext   = {{(WORD_W-BYTE_W){1'b0}}, byte_q};
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    count_d     = count_q;
    byte_d      = byte_q;
    last_d      = last_q;
    fin_idx_d   = fin_idx_q;
    fin_v_d     = fin_v_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_req     = '{start: 1'b0, a: fin_v_q, b: MIX_MULT1};
    sum1        = lane_q[1] + byte_ext + GOLDEN;
    mix         = lane_q[fin_idx_q] ^ (count_q + FIN_OFFSET[fin_idx_q]);
    mix3        = '0;

    case (state_q)
      ST_IDLE: begin
        // seed write before any byte of the block reloads the lanes at once
        if (seed_we_i && (count_q == '0)) begin
          for (int i = 0; i < LANE_COUNT; i++) begin
            lane_d[i] = seed_i ^ LANE_START[i];
          end
        end
        if (in_valid_i) begin
          byte_d    = data_byte_i;
          last_d    = last_i;
          fin_idx_d = '0;
          if (has_byte_i) begin
            state_d = ST_MUL_L0;
          end else if (last_i) begin
            state_d = ST_FIN_MIX;
          end
        end
      end
      ST_MUL_L0: begin
        mul_req.start = !mul_rsp.busy && !mul_rsp.done;
        mul_req.a     = lane_q[0] ^ (byte_ext + count_q);
        mul_req.b     = LANE0_MULT;
        if (mul_rsp.done) begin
          lane_d[0] = mul_rsp.p;
          lane_d[1] = {sum1[WORD_W-14:0], sum1[WORD_W-1:WORD_W-13]} ^ mul_rsp.p;
          state_d   = ST_MUL_IX;
        end
      end
      ST_MUL_IX: begin
        mul_req.start = !mul_rsp.busy && !mul_rsp.done;
        mul_req.a     = count_q;
        mul_req.b     = IDX_MULT;
        if (mul_rsp.done) begin
          fin_v_d = lane_q[2] + (byte_ext ^ mul_rsp.p);
          state_d = ST_MUL_L2;
        end
      end
      ST_MUL_L2: begin
        mul_req.start = !mul_rsp.busy && !mul_rsp.done;
        mul_req.a     = fin_v_q;
        mul_req.b     = LANE2_MULT;
        if (mul_rsp.done) begin
          mix3      = lane_q[3] ^ (mul_rsp.p + byte_ext);
          lane_d[2] = mul_rsp.p;
          lane_d[3] = {mix3[WORD_W-30:0], mix3[WORD_W-1:WORD_W-29]} + LANE3_ADD;
          count_d   = count_q + 64'd1;
          state_d   = last_q ? ST_FIN_MIX : ST_IDLE;
        end
      end
      ST_FIN_MIX: begin
        fin_v_d = mix ^ (mix >> 30);
        state_d = ST_FIN_M1;
      end
      ST_FIN_M1: begin
        mul_req.start = !mul_rsp.busy && !mul_rsp.done;
        mul_req.b     = MIX_MULT1;
        if (mul_rsp.done) begin
          fin_v_d = mul_rsp.p ^ (mul_rsp.p >> 27);
          state_d = ST_FIN_M2;
        end
      end
      ST_FIN_M2: begin
        mul_req.start = !mul_rsp.busy && !mul_rsp.done;
        mul_req.b     = MIX_MULT2;
        if (mul_rsp.done) begin
          // finished lane goes back into its own register
          lane_d[fin_idx_q] = mul_rsp.p ^ (mul_rsp.p >> 31);
          if (fin_idx_q == LANE_IDX_W'(LANE_COUNT - 1)) begin
            state_d = ST_EMIT;
          end else begin
            fin_idx_d = fin_idx_q + 1'b1;
            state_d   = ST_FIN_MIX;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          word_d      = lane_q;
          out_valid_d = 1'b1;
          count_d     = '0;
          for (int i = 0; i < LANE_COUNT; i++) begin
            lane_d[i] = seed_q ^ LANE_START[i];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
      fin_idx_q   <= '0;
      last_q      <= 1'b0;
      for (int i = 0; i < LANE_COUNT; i++) begin
        lane_q[i] <= LANE_START[i];
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      fin_idx_q   <= fin_idx_d;
      last_q      <= last_d;
      lane_q      <= lane_d;
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    fin_v_q <= fin_v_d;
    word_q  <= word_d;
  end

  assign out_valid_o    = out_valid_q;
  assign digest_word0_o = word_q[0];
  assign digest_word1_o = word_q[1];
  assign digest_word2_o = word_q[2];
  assign digest_word3_o = word_q[3];

endmodule
